### hdl/casss_pkg.sv
// Shared widths, stage map, beat layout and types for the collision-avoidance
// sense selection block. No dependencies; every other file refers to it by scope.
`default_nettype none

package casss_pkg;

   // Field widths.
   localparam int ALT_W      = 25;
   localparam int VS_W       = 19;
   localparam int TIME_W     = 16;
   localparam int ALIM_W     = 18;
   localparam int TVS_W      = 18;
   localparam int ACCEL_W    = 14;
   localparam int SEP_W      = 26;
   localparam int CSR_DATA_W = 18;

   // Request beat layout.
   localparam int REQ_DATA_W   = 128;
   localparam int REQ_ALT_LSB  = 0;
   localparam int REQ_VS_LSB   = REQ_ALT_LSB + ALT_W;
   localparam int REQ_IALT_LSB = REQ_VS_LSB + VS_W;
   localparam int REQ_IVS_LSB  = REQ_IALT_LSB + ALT_W;
   localparam int REQ_TIME_LSB = REQ_IVS_LSB + VS_W;
   localparam int REQ_ALIM_LSB = REQ_TIME_LSB + TIME_W;

   // Response beat layout.
   localparam int RSP_DATA_W = 56;
   localparam int RSP_USED_W = 1 + 2 * SEP_W;

   // Stop-time divider.
   localparam int NUM_W       = VS_W + 1;
   localparam int NUMER_SHIFT = 8;
   localparam int DIV_BITS    = TIME_W;
   localparam int DIV_STAGES  = DIV_BITS + 1;
   localparam int REM_W       = ACCEL_W + DIV_BITS;

   // Pipeline stage map.
   localparam int DIV_FIRST  = 1;
   localparam int ST_MIN     = DIV_FIRST + DIV_STAGES;
   localparam int ST_MUL     = ST_MIN + 1;
   localparam int ST_ACC     = ST_MUL + 1;
   localparam int ST_SUM     = ST_ACC + 1;
   localparam int ST_SAT     = ST_SUM + 1;
   localparam int ST_OUT     = ST_SAT + 1;
   localparam int NUM_STAGES = ST_OUT + 1;
   localparam int IN_FLIGHT_W = $clog2(NUM_STAGES + 1);

   // Datapath widths, in units of 2^-17 ft after the sum stage.
   localparam int QQ_W        = 2 * TIME_W;
   localparam int PV_W        = TIME_W + 1 + VS_W;
   localparam int LT_W        = TIME_W + TVS_W;
   localparam int QQA_W       = QQ_W + ACCEL_W;
   localparam int MID_W       = PV_W + 2;
   localparam int DALT_W      = ALT_W + 1;
   localparam int FINE_W      = 49;
   localparam int MID_SHIFT   = 9;
   localparam int FINE_SHIFT  = 17;
   localparam int SHR_W       = FINE_W - FINE_SHIFT;

   localparam logic [TVS_W-1:0]   TVS_RESET   = TVS_W'(6400);
   localparam logic [ACCEL_W-1:0] ACCEL_RESET = ACCEL_W'(2048);

   localparam logic SENSE_UP   = 1'b0;
   localparam logic SENSE_DOWN = 1'b1;

   typedef enum logic [0:0] {
      CSR_TARGET_VSPEED  = 1'b0,
      CSR_MANEUVER_ACCEL = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic signed [ALT_W-1:0] own_altitude;
      logic signed [VS_W-1:0]  own_vspeed;
      logic signed [ALT_W-1:0] intruder_altitude;
      logic signed [VS_W-1:0]  intruder_vspeed;
      logic [TIME_W-1:0]       lookahead_time;
      logic [ALIM_W-1:0]       altitude_limit;
   } item_type;

   typedef struct packed {
      logic zero;
      logic sat;
   } div_flag_type;

   typedef logic [REM_W-1:0]         rem_type;
   typedef logic signed [FINE_W-1:0] fine_type;

endpackage

`default_nettype wire

### hdl/collision_avoidance_sense_select.sv
// Top level of the collision-avoidance sense selection block: stream ports, register
// port, pipeline control and datapath. Uses casss_pkg and casss_stop_div.
//
// Each request beat carries one own/intruder pair; the block projects own altitude for
// an upward and a downward maneuver, returns both separations and picks a sense with a
// bias to the non-crossing direction. The pipeline has 24 stages and takes one beat per
// clock until a stall at the output has filled every stage. The depth is set by the
// stop-time dividers, which resolve one quotient bit per stage. A stall at the output
// holds only the stages that have no empty stage after them, so bubbles close up and
// requests are still taken until every stage holds a beat. Write the target speed and
// acceleration registers only while no beat is in flight.
`default_nettype none

module collision_avoidance_sense_select (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // own_altitude, own_vspeed, intruder_altitude, intruder_vspeed, lookahead_time,
   // altitude_limit, zero padding
   input  wire logic [casss_pkg::REQ_DATA_W-1:0]    req_tdata,
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   // sense, up_separation, down_separation, zero padding
   output logic [casss_pkg::RSP_DATA_W-1:0]         rsp_tdata,
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   input  wire logic                                csr_we,
   input  wire casss_pkg::csr_index_type            csr_index,
   input  wire logic [casss_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   function automatic logic signed [casss_pkg::SEP_W-1:0] sat_sep(
      input casss_pkg::fine_type x
   );
      logic signed [casss_pkg::SHR_W-1:0] shr;
      logic [casss_pkg::SHR_W-casss_pkg::SEP_W:0] top;
      shr = x[casss_pkg::FINE_W-1:casss_pkg::FINE_SHIFT];
      top = shr[casss_pkg::SHR_W-1:casss_pkg::SEP_W-1];
      if ((&top) || !(|top)) begin
         return shr[casss_pkg::SEP_W-1:0];
      end
      return {shr[casss_pkg::SHR_W-1], {(casss_pkg::SEP_W-1){~shr[casss_pkg::SHR_W-1]}}};
   endfunction

   logic [casss_pkg::TVS_W-1:0]   tvs_ff;
   logic [casss_pkg::ACCEL_W-1:0] accel_ff;

   logic [casss_pkg::NUM_STAGES-1:0] valid_ff;
   logic [casss_pkg::NUM_STAGES-1:0] valid_in;
   logic [casss_pkg::NUM_STAGES-1:0] stage_en;
   logic                             out_ready;

   casss_pkg::item_type item_in;
   casss_pkg::item_type item_ff [0:casss_pkg::ST_MIN-1];

   logic signed [casss_pkg::NUM_W-1:0] num_up;
   logic signed [casss_pkg::NUM_W-1:0] num_dn;
   logic [casss_pkg::TIME_W-1:0]       stop_up;
   logic [casss_pkg::TIME_W-1:0]       stop_dn;

   logic [casss_pkg::TIME_W-1:0] qu_in, lu_in, qd_in, ld_in;
   logic [casss_pkg::TIME_W-1:0] qu_ff, lu_ff, qd_ff, ld_ff;
   casss_pkg::item_type          mitem_ff;

   logic [casss_pkg::QQ_W-1:0]          qq_u_in, qq_d_in, qq_u_ff, qq_d_ff;
   logic signed [casss_pkg::PV_W-1:0]   pv_u_in, pv_d_in, pv_u_ff, pv_d_ff;
   logic [casss_pkg::LT_W-1:0]          lt_u_in, lt_d_in, lt_u_ff, lt_d_ff;
   logic signed [casss_pkg::PV_W-1:0]   tiv_in, tiv_ff;
   logic signed [casss_pkg::DALT_W-1:0] dalt_in, dalt_mul_ff, dalt_acc_ff;
   logic [casss_pkg::ALIM_W-1:0]        alim_mul_ff, alim_acc_ff, alim_sum_ff, alim_sat_ff;

   logic [casss_pkg::QQA_W-1:0]        qqa_u_in, qqa_d_in, qqa_u_ff, qqa_d_ff;
   logic signed [casss_pkg::MID_W-1:0] mid_u_in, mid_d_in, mid_u_ff, mid_d_ff;

   casss_pkg::fine_type fine_u_in, fine_d_in, fine_u_ff, fine_d_ff;
   logic                above_sum_ff, below_sum_ff, above_sat_ff, below_sat_ff;

   logic signed [casss_pkg::SEP_W-1:0] up_sat_ff, dn_sat_ff;
   logic signed [casss_pkg::SEP_W-1:0] up_out_ff, dn_out_ff;
   logic                               sense_in, sense_ff;
   logic                               up_clear, dn_clear;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         tvs_ff   <= casss_pkg::TVS_RESET;
         accel_ff <= casss_pkg::ACCEL_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            casss_pkg::CSR_TARGET_VSPEED: begin
               tvs_ff <= csr_wdata[casss_pkg::TVS_W-1:0];
            end
            casss_pkg::CSR_MANEUVER_ACCEL: begin
               accel_ff <= csr_wdata[casss_pkg::ACCEL_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // A stage moves when any stage from it to the output is empty or the output drains.
   always_comb begin
      out_ready = !valid_ff[casss_pkg::ST_OUT] || rsp_tready;
      for (int k = 0; k < casss_pkg::NUM_STAGES; k++) begin
         stage_en[k] = out_ready ||
            ((valid_ff & ({casss_pkg::NUM_STAGES{1'b1}} << k)) !=
             ({casss_pkg::NUM_STAGES{1'b1}} << k));
      end
      valid_in[0] = stage_en[0] ? req_tvalid : valid_ff[0];
      for (int k = 1; k < casss_pkg::NUM_STAGES; k++) begin
         valid_in[k] = stage_en[k] ? valid_ff[k-1] : valid_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_tready = stage_en[0];
   assign rsp_tvalid = valid_ff[casss_pkg::ST_OUT];

   always_comb begin
      item_in.own_altitude      = req_tdata[casss_pkg::REQ_ALT_LSB +: casss_pkg::ALT_W];
      item_in.own_vspeed        = req_tdata[casss_pkg::REQ_VS_LSB +: casss_pkg::VS_W];
      item_in.intruder_altitude = req_tdata[casss_pkg::REQ_IALT_LSB +: casss_pkg::ALT_W];
      item_in.intruder_vspeed   = req_tdata[casss_pkg::REQ_IVS_LSB +: casss_pkg::VS_W];
      item_in.lookahead_time    = req_tdata[casss_pkg::REQ_TIME_LSB +: casss_pkg::TIME_W];
      item_in.altitude_limit    = req_tdata[casss_pkg::REQ_ALIM_LSB +: casss_pkg::ALIM_W];
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         item_ff[0] <= item_in;
      end
      for (int k = 1; k < casss_pkg::ST_MIN; k++) begin
         if (stage_en[k]) begin
            item_ff[k] <= item_ff[k-1];
         end
      end
   end

   // Speed still to gain in each direction before the target speed is reached.
   assign num_up = $signed({2'b00, tvs_ff}) - item_ff[0].own_vspeed;
   assign num_dn = $signed({2'b00, tvs_ff}) + item_ff[0].own_vspeed;

   casss_stop_div u_div_up (
      .clock     (clock),
      .stage_en  (stage_en[casss_pkg::DIV_FIRST +: casss_pkg::DIV_STAGES]),
      .num       (num_up),
      .accel     (accel_ff),
      .stop_time (stop_up)
   );

   casss_stop_div u_div_dn (
      .clock     (clock),
      .stage_en  (stage_en[casss_pkg::DIV_FIRST +: casss_pkg::DIV_STAGES]),
      .num       (num_dn),
      .accel     (accel_ff),
      .stop_time (stop_dn)
   );

   // Split the lookahead into the accelerating part and the constant-speed part.
   always_comb begin
      qu_in = (item_ff[casss_pkg::ST_MIN-1].lookahead_time < stop_up) ?
              item_ff[casss_pkg::ST_MIN-1].lookahead_time : stop_up;
      qd_in = (item_ff[casss_pkg::ST_MIN-1].lookahead_time < stop_dn) ?
              item_ff[casss_pkg::ST_MIN-1].lookahead_time : stop_dn;
      lu_in = item_ff[casss_pkg::ST_MIN-1].lookahead_time - qu_in;
      ld_in = item_ff[casss_pkg::ST_MIN-1].lookahead_time - qd_in;
   end

   always_ff @(posedge clock) begin
      if (stage_en[casss_pkg::ST_MIN]) begin
         qu_ff    <= qu_in;
         lu_ff    <= lu_in;
         qd_ff    <= qd_in;
         ld_ff    <= ld_in;
         mitem_ff <= item_ff[casss_pkg::ST_MIN-1];
      end
   end

   always_comb begin
      qq_u_in = qu_ff * qu_ff;
      qq_d_in = qd_ff * qd_ff;
      pv_u_in = $signed({1'b0, qu_ff}) * mitem_ff.own_vspeed;
      pv_d_in = $signed({1'b0, qd_ff}) * mitem_ff.own_vspeed;
      lt_u_in = lu_ff * tvs_ff;
      lt_d_in = ld_ff * tvs_ff;
      tiv_in  = $signed({1'b0, mitem_ff.lookahead_time}) * mitem_ff.intruder_vspeed;
      dalt_in = mitem_ff.own_altitude - mitem_ff.intruder_altitude;
   end

   always_ff @(posedge clock) begin
      if (stage_en[casss_pkg::ST_MUL]) begin
         qq_u_ff     <= qq_u_in;
         qq_d_ff     <= qq_d_in;
         pv_u_ff     <= pv_u_in;
         pv_d_ff     <= pv_d_in;
         lt_u_ff     <= lt_u_in;
         lt_d_ff     <= lt_d_in;
         tiv_ff      <= tiv_in;
         dalt_mul_ff <= dalt_in;
         alim_mul_ff <= mitem_ff.altitude_limit;
      end
   end

   always_comb begin
      qqa_u_in = qq_u_ff * accel_ff;
      qqa_d_in = qq_d_ff * accel_ff;
      mid_u_in = pv_u_ff + $signed({1'b0, lt_u_ff}) - tiv_ff;
      mid_d_in = $signed({1'b0, lt_d_ff}) - pv_d_ff + tiv_ff;
   end

   always_ff @(posedge clock) begin
      if (stage_en[casss_pkg::ST_ACC]) begin
         qqa_u_ff    <= qqa_u_in;
         qqa_d_ff    <= qqa_d_in;
         mid_u_ff    <= mid_u_in;
         mid_d_ff    <= mid_d_in;
         dalt_acc_ff <= dalt_mul_ff;
         alim_acc_ff <= alim_mul_ff;
      end
   end

   always_comb begin
      fine_u_in = casss_pkg::fine_type'($signed({1'b0, qqa_u_ff}))
                + (casss_pkg::fine_type'(mid_u_ff) <<< casss_pkg::MID_SHIFT)
                + (casss_pkg::fine_type'(dalt_acc_ff) <<< casss_pkg::FINE_SHIFT);
      fine_d_in = casss_pkg::fine_type'($signed({1'b0, qqa_d_ff}))
                + (casss_pkg::fine_type'(mid_d_ff) <<< casss_pkg::MID_SHIFT)
                - (casss_pkg::fine_type'(dalt_acc_ff) <<< casss_pkg::FINE_SHIFT);
   end

   always_ff @(posedge clock) begin
      if (stage_en[casss_pkg::ST_SUM]) begin
         fine_u_ff    <= fine_u_in;
         fine_d_ff    <= fine_d_in;
         above_sum_ff <= !dalt_acc_ff[casss_pkg::DALT_W-1] && (dalt_acc_ff != '0);
         below_sum_ff <= dalt_acc_ff[casss_pkg::DALT_W-1];
         alim_sum_ff  <= alim_acc_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[casss_pkg::ST_SAT]) begin
         up_sat_ff    <= sat_sep(fine_u_ff);
         dn_sat_ff    <= sat_sep(fine_d_ff);
         above_sat_ff <= above_sum_ff;
         below_sat_ff <= below_sum_ff;
         alim_sat_ff  <= alim_sum_ff;
      end
   end

   always_comb begin
      up_clear = !up_sat_ff[casss_pkg::SEP_W-1] &&
                 (up_sat_ff[casss_pkg::SEP_W-2:0] >=
                  (casss_pkg::SEP_W-1)'(alim_sat_ff));
      dn_clear = !dn_sat_ff[casss_pkg::SEP_W-1] &&
                 (dn_sat_ff[casss_pkg::SEP_W-2:0] >=
                  (casss_pkg::SEP_W-1)'(alim_sat_ff));
      if (above_sat_ff && up_clear) begin
         sense_in = casss_pkg::SENSE_UP;
      end else if (below_sat_ff && dn_clear) begin
         sense_in = casss_pkg::SENSE_DOWN;
      end else if (up_sat_ff >= dn_sat_ff) begin
         sense_in = casss_pkg::SENSE_UP;
      end else begin
         sense_in = casss_pkg::SENSE_DOWN;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[casss_pkg::ST_OUT]) begin
         sense_ff  <= sense_in;
         up_out_ff <= up_sat_ff;
         dn_out_ff <= dn_sat_ff;
      end
   end

   assign rsp_tdata = {{(casss_pkg::RSP_DATA_W - casss_pkg::RSP_USED_W){1'b0}},
                       dn_out_ff, up_out_ff, sense_ff};

endmodule

`default_nettype wire

### hdl/casss_stop_div.sv
// Pipelined restoring divider for the maneuver stop time, one quotient bit per stage.
// Uses casss_pkg; stage enables come from the pipeline control in the top level.
`default_nettype none

module casss_stop_div (
   input  wire logic                                 clock,
   input  wire logic [casss_pkg::DIV_STAGES-1:0]     stage_en,
   input  wire logic signed [casss_pkg::NUM_W-1:0]   num,
   input  wire logic [casss_pkg::ACCEL_W-1:0]        accel,
   output logic [casss_pkg::TIME_W-1:0]              stop_time
);

   casss_pkg::rem_type             rem_ff   [0:casss_pkg::DIV_BITS];
   casss_pkg::rem_type             rem_in   [0:casss_pkg::DIV_BITS];
   logic [casss_pkg::TIME_W-1:0]   quo_ff   [0:casss_pkg::DIV_BITS];
   logic [casss_pkg::TIME_W-1:0]   quo_in   [0:casss_pkg::DIV_BITS];
   casss_pkg::div_flag_type        flag_ff  [0:casss_pkg::DIV_BITS];
   casss_pkg::div_flag_type        flag_in  [0:casss_pkg::DIV_BITS];

   always_comb begin
      flag_in[0].zero = num[casss_pkg::NUM_W-1] || (num == '0);
      rem_in[0] = casss_pkg::rem_type'(num[casss_pkg::NUM_W-2:0]) << casss_pkg::NUMER_SHIFT;
      flag_in[0].sat = !flag_in[0].zero &&
         (rem_in[0] >= (casss_pkg::rem_type'(accel) << casss_pkg::DIV_BITS));
      quo_in[0] = '0;
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         rem_ff[0]  <= rem_in[0];
         quo_ff[0]  <= quo_in[0];
         flag_ff[0] <= flag_in[0];
      end
   end

   for (genvar j = 1; j <= casss_pkg::DIV_BITS; j++) begin : g_bit
      logic [casss_pkg::REM_W:0] diff;

      assign diff = {1'b0, rem_ff[j-1]} -
                    {1'b0, casss_pkg::rem_type'(accel) << (casss_pkg::DIV_BITS - j)};

      always_comb begin
         flag_in[j] = flag_ff[j-1];
         quo_in[j]  = quo_ff[j-1];
         rem_in[j]  = rem_ff[j-1];
         if (!diff[casss_pkg::REM_W]) begin
            rem_in[j] = diff[casss_pkg::REM_W-1:0];
            quo_in[j][casss_pkg::DIV_BITS-j] = 1'b1;
         end
      end

      always_ff @(posedge clock) begin
         if (stage_en[j]) begin
            rem_ff[j]  <= rem_in[j];
            quo_ff[j]  <= quo_in[j];
            flag_ff[j] <= flag_in[j];
         end
      end
   end

   always_comb begin
      if (flag_ff[casss_pkg::DIV_BITS].zero) begin
         stop_time = '0;
      end else if (flag_ff[casss_pkg::DIV_BITS].sat) begin
         stop_time = '1;
      end else begin
         stop_time = quo_ff[casss_pkg::DIV_BITS];
      end
   end

endmodule

`default_nettype wire

### hdl/casss_checker.sv
// Port-level checks for collision_avoidance_sense_select, attached by the bind below.
// Uses casss_pkg for the pipeline depth.
`default_nettype none

module casss_checker (
   input wire logic                                clock,
   input wire logic                                reset,
   input wire logic                                req_tvalid,
   input wire logic                                req_tready,
   input wire logic [casss_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   input wire logic                                rsp_tvalid,
   input wire logic                                rsp_tready
);

   logic [casss_pkg::IN_FLIGHT_W-1:0] in_flight_ff;
   logic [casss_pkg::IN_FLIGHT_W-1:0] in_flight_in;

   always_comb begin
      in_flight_in = in_flight_ff;
      if (req_tvalid && req_tready) begin
         in_flight_in = in_flight_in + 1'b1;
      end
      if (rsp_tvalid && rsp_tready) begin
         in_flight_in = in_flight_in - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_flight_ff <= '0;
      end else begin
         in_flight_ff <= in_flight_in;
      end
   end

   // A result beat that is not taken stays, with the same data.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response beat dropped or changed while stalled");

   // With nothing waiting at the output, the input side must be open.
   a_ready_when_drained: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("request side blocked while the output is empty");

   // Every result beat belongs to an accepted request beat.
   a_no_invented: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> in_flight_ff != '0)
      else $error("response beat without a pending request");

   // The pipeline never holds more beats than it has stages.
   a_depth: assert property (@(posedge clock) disable iff (reset)
      in_flight_ff <= casss_pkg::IN_FLIGHT_W'(casss_pkg::NUM_STAGES))
      else $error("more beats in flight than pipeline stages");

endmodule

bind collision_avoidance_sense_select casss_checker u_casss_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready)
);

`default_nettype wire
